@@ hdl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for integer_to_ascii_digits
// Format codes, BCD digit vector type and character helpers.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int unsigned ValueW   = 64;
	localparam int unsigned NDigits  = 20;
	localparam int unsigned BcdW     = 4 * NDigits;
	localparam int unsigned CntW     = 5;
	// Double-dabble split: DdStages stages of DdSteps steps cover all ValueW bits.
	localparam int unsigned DdSteps  = 8;
	localparam int unsigned DdStages = ValueW / DdSteps;

	typedef enum logic [1:0] {
		OP_UDEC = 2'd0,
		OP_HEXL = 2'd1,
		OP_HEXU = 2'd2,
		OP_SDEC = 2'd3
	} op_t;

	localparam logic [7:0] CharMinus = 8'h2d;

	typedef logic [BcdW-1:0] bcd_t;

	// Map one nibble to its ASCII character.
	function automatic logic [7:0] nib_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'd0, d};
		end else if (upper) begin
			c = 8'h37 + {4'd0, d};
		end else begin
			c = 8'h57 + {4'd0, d};
		end
		return c;
	endfunction

	// Add-3 correction of every BCD digit, then shift in one bit.
	function automatic bcd_t dd_step(input bcd_t b, input logic bit_in);
		bcd_t a;
		a = b;
		for (int k = 0; k < NDigits; k++) begin
			if (a[4*k +: 4] >= 4'd5) begin
				a[4*k +: 4] = a[4*k +: 4] + 4'd3;
			end
		end
		return {a[BcdW-2:0], bit_in};
	endfunction

endpackage

@@ hdl/i2a_dd_stage.sv @@
// ----------------------------------------------------------------------------
// i2a_dd_stage: one register stage of the double-dabble converter
// Applies a fixed number of shift-add steps and registers the result.
// ----------------------------------------------------------------------------
module i2a_dd_stage #(
	parameter int unsigned Steps = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         in_valid,
	input  i2a_pkg::bcd_t                in_bcd,
	input  logic [i2a_pkg::ValueW-1:0]   in_bin,
	input  logic [1:0]                   in_op,
	input  logic                         in_neg,
	output logic                         out_valid,
	output i2a_pkg::bcd_t                out_bcd,
	output logic [i2a_pkg::ValueW-1:0]   out_bin,
	output logic [1:0]                   out_op,
	output logic                         out_neg
);

	i2a_pkg::bcd_t                bcd_n;
	logic [i2a_pkg::ValueW-1:0]   bin_n;

	always_comb begin
		bcd_n = in_bcd;
		bin_n = in_bin;
		for (int s = 0; s < Steps; s++) begin
			bcd_n = i2a_pkg::dd_step(bcd_n, bin_n[i2a_pkg::ValueW-1]);
			bin_n = {bin_n[i2a_pkg::ValueW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_bcd <= bcd_n;
			out_bin <= bin_n;
			out_op  <= in_op;
			out_neg <= in_neg;
		end
	end

endmodule

@@ hdl/integer_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: binary integer to ASCII text
// Decimal (unsigned 64 / signed 32) and hex text, one string per request.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields (low bit up)         tuser / tlast
// s_axis    in   op[1:0], value[65:2], pad to 72   -
// m_axis    out  char_code[7:0]                    tlast = last
//
// Input is taken by a pipeline: one negate stage, eight double-dabble
// stages of eight steps each, and the emitter load (10 register stages).
// A request can enter in any cycle in which the emitter is idle or hands over
// its last character; the emitter drains one item of 1 to 20 characters, one
// character per cycle while m_axis_tready is high. An output stall holds every
// stage; nothing drops.
// Reset clears valid bits and emitter control only.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // op[1:0], value[65:2], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // char_code[7:0]
	output logic        m_axis_tlast
);

	localparam int unsigned NStages = i2a_pkg::DdStages;
	localparam int unsigned CntW    = i2a_pkg::CntW;

	// Emitter (last stage) state.
	logic                 em_busy_q;
	logic [7:0]           em_chars_q [i2a_pkg::NDigits+1];
	logic [7:0]           em_chars_n [i2a_pkg::NDigits+1];
	logic [CntW-1:0]      em_len_q;
	logic [CntW-1:0]      em_idx_q;
	logic                 em_done;
	logic                 advance;

	assign em_done = em_busy_q && m_axis_tready && (em_idx_q == em_len_q);
	// Whole pipeline moves when the emitter can take a new item.
	assign advance = !em_busy_q || em_done;

	// Stage 1: format decode and negation.
	logic                         v_s1;
	logic [i2a_pkg::ValueW-1:0]   bin_s1;
	logic [1:0]                   op_s1;
	logic                         neg_s1;
	logic [1:0]                   op_in;
	logic [i2a_pkg::ValueW-1:0]   val_in;
	logic [31:0]                  low_mag;

	assign op_in  = s_axis_tdata[1:0];
	assign val_in = s_axis_tdata[65:2];
	assign low_mag = val_in[31] ? (~val_in[31:0] + 32'd1) : val_in[31:0];
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1 <= op_in;
			unique case (i2a_pkg::op_t'(op_in))
				i2a_pkg::OP_SDEC: begin
					bin_s1 <= {32'd0, low_mag};   // leading zeros leave the BCD at zero
					neg_s1 <= val_in[31];
				end
				default: begin
					bin_s1 <= val_in;
					neg_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Double-dabble chain. Signed magnitudes enter zero-extended, so the first
	// 32 steps shift zeros into an all-zero BCD and change nothing.
	logic                         dv  [NStages+1];
	i2a_pkg::bcd_t                dbcd[NStages+1];
	logic [i2a_pkg::ValueW-1:0]   dbin[NStages+1];
	logic [1:0]                   dop [NStages+1];
	logic                         dneg[NStages+1];

	assign dv[0]   = v_s1;
	assign dbcd[0] = '0;
	assign dbin[0] = bin_s1;
	assign dop[0]  = op_s1;
	assign dneg[0] = neg_s1;

	for (genvar g = 0; g < NStages; g++) begin : g_dd
		i2a_dd_stage #(.Steps(i2a_pkg::DdSteps)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_valid (dv[g]),
			.in_bcd   (dbcd[g]),
			.in_bin   (dbin[g]),
			.in_op    (dop[g]),
			.in_neg   (dneg[g]),
			.out_valid(dv[g+1]),
			.out_bcd  (dbcd[g+1]),
			.out_bin  (dbin[g+1]),
			.out_op   (dop[g+1]),
			.out_neg  (dneg[g+1])
		);
	end

	// Hex reads the raw value, which the dd chain shifted out, so carry it
	// alongside.
	logic [i2a_pkg::ValueW-1:0] raw_q [NStages+1];
	assign raw_q[0] = bin_s1;
	for (genvar r = 0; r < NStages; r++) begin : g_raw
		always_ff @(posedge clk) begin
			if (advance) begin
				raw_q[r+1] <= raw_q[r];
			end
		end
	end

	// Digit prep: pick nibble source and count significant digits.
	logic [i2a_pkg::BcdW-1:0] digits;
	logic                     hexm;
	logic [CntW-1:0]          nd;

	always_comb begin
		hexm = (dop[NStages] == i2a_pkg::OP_HEXL) || (dop[NStages] == i2a_pkg::OP_HEXU);
		digits = hexm ? {16'd0, raw_q[NStages]} : dbcd[NStages];
		nd = CntW'(1);
		for (int k = 1; k < i2a_pkg::NDigits; k++) begin
			if (digits[4*k +: 4] != 4'd0) begin
				nd = CntW'(k + 1);
			end
		end
	end

	// Build the whole string, MSD first, minus sign in front when negative.
	always_comb begin
		for (int j = 0; j <= i2a_pkg::NDigits; j++) begin
			em_chars_n[j] = 8'h00;
		end
		if (dneg[NStages]) begin
			em_chars_n[0] = i2a_pkg::CharMinus;
		end
		for (int j = 0; j < i2a_pkg::NDigits; j++) begin
			if (CntW'(j) < nd) begin
				em_chars_n[j + (dneg[NStages] ? 1 : 0)] = i2a_pkg::nib_char(
					digits[4*(int'(nd) - 1 - j) +: 4],
					dop[NStages] == i2a_pkg::OP_HEXU);
			end
		end
	end

	// Stage: load emitter with the whole string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			em_idx_q  <= '0;
			em_len_q  <= '0;
		end else if (advance) begin
			em_busy_q <= dv[NStages];
			em_idx_q  <= '0;
			em_len_q  <= nd - CntW'(1) + CntW'(dneg[NStages]);
		end else if (m_axis_tready) begin
			em_idx_q <= em_idx_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			em_chars_q <= em_chars_n;
		end
	end

	assign m_axis_tvalid = em_busy_q;
	assign m_axis_tdata  = em_chars_q[em_idx_q];
	assign m_axis_tlast  = (em_idx_q == em_len_q);

	// Index never passes the string length while a string is held.
	ap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		em_busy_q |-> (em_idx_q <= em_len_q))
		else $error("emitter index beyond length");
	// Input is refused while an unfinished string is held.
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(em_busy_q && !m_axis_tlast) |-> !s_axis_tready)
		else $error("pipeline advanced mid-string");
	// Text never exceeds 20 characters.
	ap_len: assert property (@(posedge clk) disable iff (!arst_n)
		em_busy_q |-> (em_len_q < CntW'(i2a_pkg::NDigits)))
		else $error("string length out of range");

endmodule
